>>> rtl/assert_macros.svh
// Assertion macros, included by rotation_matrix_to_quaternion.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/rmq_pkg.sv
// Types and constants for the rotation matrix to quaternion pipeline.
// No dependencies.
package rmq_pkg;

  localparam int FIELD_W   = 16;
  localparam int TERM_W    = 17;  // clamped winning term, unsigned
  localparam int MAG_W     = 17;  // magnitude of an off-diagonal sum or difference
  localparam int ROOT_W    = 15;  // floor(sqrt(term << 12))
  localparam int RAD_SHIFT = 12;
  localparam int NUM_W     = 30;
  localparam int DEN_W     = 16;
  localparam int QUO_W     = 18;
  localparam int DIV_SHIFT = 13;

  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;

  localparam logic [ROOT_W-1:0]  V_MIN_Q14 = ROOT_W'(2048);
  localparam logic [FIELD_W-1:0] ONE_Q14   = FIELD_W'(16384);

  typedef struct packed {
    logic signed [FIELD_W-1:0] m_r1c1;
    logic signed [FIELD_W-1:0] m_r1c2;
    logic signed [FIELD_W-1:0] m_r1c3;
    logic signed [FIELD_W-1:0] m_r2c1;
    logic signed [FIELD_W-1:0] m_r2c2;
    logic signed [FIELD_W-1:0] m_r2c3;
    logic signed [FIELD_W-1:0] m_r3c1;
    logic signed [FIELD_W-1:0] m_r3c2;
    logic signed [FIELD_W-1:0] m_r3c3;
  } rmq_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quat_x;
    logic signed [FIELD_W-1:0] quat_y;
    logic signed [FIELD_W-1:0] quat_z;
    logic signed [FIELD_W-1:0] quat_w;
  } rmq_out_t;

endpackage

>>> rtl/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on rmq_pkg.
module rmq_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rmq_pkg::TERM_W-1:0]   big_i,
  output logic [rmq_pkg::ROOT_W-1:0]   root_o
);

  localparam int N     = rmq_pkg::ROOT_W;
  localparam int TW    = rmq_pkg::TERM_W;
  localparam int SH    = rmq_pkg::RAD_SHIFT;
  localparam int PAD_W = 2 * N - TW - SH;

  logic [TW-1:0] big_r  [N];
  logic [N-1:0]  root_r [N];
  logic [N+1:0]  rem_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic [TW-1:0]  big_in;
    logic [N-1:0]   root_in;
    logic [N+1:0]   rem_in;
    logic [2*N-1:0] rad;
    logic [N+3:0]   cur;
    logic [N+3:0]   trial;
    logic [N+1:0]   rem_nxt;
    logic [N-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign big_in  = big_i;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign big_in  = big_r[k-1];
      assign root_in = root_r[k-1];
      assign rem_in  = rem_r[k-1];
    end

    assign rad   = {{PAD_W{1'b0}}, big_in, {SH{1'b0}}};
    assign cur   = {rem_in, rad[2*(N-1-k)+1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_comb begin
      if (cur >= trial) begin
        rem_nxt  = (N+2)'(cur - trial);
        root_nxt = {root_in[N-2:0], 1'b1};
      end else begin
        rem_nxt  = cur[N+1:0];
        root_nxt = {root_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        big_r[k]  <= big_in;
        root_r[k] <= root_nxt;
        rem_r[k]  <= rem_nxt;
      end
    end
  end

  assign root_o = root_r[N-1];

endmodule

>>> rtl/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage, then sign and saturation.
// Depends on rmq_pkg.
module rmq_div (
  input  logic                                clk,
  input  logic                                en,
  input  logic [rmq_pkg::NUM_W-1:0]           num_i,
  input  logic [rmq_pkg::DEN_W-1:0]           den_i,
  input  logic                                neg_i,
  output logic signed [rmq_pkg::FIELD_W-1:0]  q_o
);

  localparam int Q  = rmq_pkg::QUO_W;
  localparam int NW = rmq_pkg::NUM_W;
  localparam int DW = rmq_pkg::DEN_W;
  localparam int RW = DW + 1;
  localparam int FW = rmq_pkg::FIELD_W;

  logic [NW-1:0] num_r [Q];
  logic [DW-1:0] den_r [Q];
  logic          neg_r [Q];
  logic [Q-1:0]  quo_r [Q];
  logic [RW-1:0] rem_r [Q];

  logic [FW-1:0]        mag;
  logic signed [FW-1:0] q_r;

  for (genvar k = 0; k < Q; k++) begin : g_st
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic          neg_in;
    logic [Q-1:0]  quo_in;
    logic [RW-1:0] rem_in;
    logic [RW:0]   cur;
    logic [RW-1:0] rem_nxt;
    logic          bit_nxt;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign neg_in = neg_i;
      assign quo_in = '0;
      // top bits of the numerator are always below the divisor
      assign rem_in = {{(RW-(NW-Q)){1'b0}}, num_i[NW-1:Q]};
    end else begin : g_next
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign neg_in = neg_r[k-1];
      assign quo_in = quo_r[k-1];
      assign rem_in = rem_r[k-1];
    end

    assign cur = {rem_in, num_in[Q-1-k]};

    always_comb begin
      if (cur >= {2'b00, den_in}) begin
        rem_nxt = RW'(cur - {2'b00, den_in});
        bit_nxt = 1'b1;
      end else begin
        rem_nxt = cur[RW-1:0];
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= num_in;
        den_r[k] <= den_in;
        neg_r[k] <= neg_in;
        quo_r[k] <= {quo_in[Q-2:0], bit_nxt};
        rem_r[k] <= rem_nxt;
      end
    end
  end

  assign mag = (quo_r[Q-1] > Q'(rmq_pkg::ONE_Q14)) ? rmq_pkg::ONE_Q14 : quo_r[Q-1][FW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= neg_r[Q-1] ? signed'(-mag) : signed'(mag);
    end
  end

  assign q_o = q_r;

endmodule

>>> rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, Shepperd's method, Q1.14 in and out.
// One transaction per cycle while no valid output is stalled.
// Depth is set by the 15-stage square root and the 18-stage divider pipelines.
// A stalled valid output freezes the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears the valid bits only.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rmq_pkg::rmq_out_t out_data
);

  localparam int SQ   = rmq_pkg::SQRT_STEPS;
  localparam int DV   = rmq_pkg::DIV_STEPS + 1;
  localparam int VLAT = SQ + DV + 2;
  localparam int FW   = rmq_pkg::FIELD_W;
  localparam int MW   = rmq_pkg::MAG_W;
  localparam int TW   = rmq_pkg::TERM_W;

  typedef struct packed {
    logic [1:0]    best;
    logic [MW-1:0] mag0;
    logic [MW-1:0] mag1;
    logic [MW-1:0] mag2;
    logic          neg0;
    logic          neg1;
    logic          neg2;
  } side_t;

  typedef struct packed {
    logic [1:0]    best;
    logic [FW-1:0] vsat;
  } tail_t;

  logic en;
  logic [VLAT-1:0] vld_r;

  // ---- stage A: terms, winner, lane sums ----
  logic signed [17:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  logic signed [17:0] t0, t1, t2, t3, tbest;
  logic signed [16:0] sxy, sxz, syz, dx, dy, dz;
  logic signed [16:0] s0, s1, s2;
  logic [1:0]         best;
  side_t              a_side_nxt, a_side_r;
  logic [TW-1:0]      a_big_nxt, a_big_r;

  assign e11 = 18'(in_data.m_r1c1);
  assign e12 = 18'(in_data.m_r1c2);
  assign e13 = 18'(in_data.m_r1c3);
  assign e21 = 18'(in_data.m_r2c1);
  assign e22 = 18'(in_data.m_r2c2);
  assign e23 = 18'(in_data.m_r2c3);
  assign e31 = 18'(in_data.m_r3c1);
  assign e32 = 18'(in_data.m_r3c2);
  assign e33 = 18'(in_data.m_r3c3);

  assign t0 = 18'sd16384 + e11 - e22 - e33;
  assign t1 = 18'sd16384 - e11 + e22 - e33;
  assign t2 = 18'sd16384 - e11 - e22 + e33;
  assign t3 = 18'sd16384 + e11 + e22 + e33;

  assign sxy = 17'(e12 + e21);
  assign sxz = 17'(e31 + e13);
  assign syz = 17'(e23 + e32);
  assign dx  = 17'(e23 - e32);
  assign dy  = 17'(e31 - e13);
  assign dz  = 17'(e12 - e21);

  always_comb begin
    logic signed [17:0] m01, m012;
    logic [1:0]         b01, b012;
    b01  = (t1 > t0) ? 2'd1 : 2'd0;
    m01  = (t1 > t0) ? t1 : t0;
    b012 = (t2 > m01) ? 2'd2 : b01;
    m012 = (t2 > m01) ? t2 : m01;
    best  = (t3 > m012) ? 2'd3 : b012;
    tbest = (t3 > m012) ? t3 : m012;
  end

  always_comb begin
    case (best)
      2'd0: begin s0 = sxy; s1 = sxz; s2 = dx; end
      2'd1: begin s0 = sxy; s1 = syz; s2 = dy; end
      2'd2: begin s0 = sxz; s1 = syz; s2 = dz; end
      default: begin s0 = dx; s1 = dy; s2 = dz; end
    endcase
  end

  assign a_big_nxt       = tbest[17] ? '0 : tbest[TW-1:0];
  assign a_side_nxt.best = best;
  assign a_side_nxt.neg0 = s0[16];
  assign a_side_nxt.neg1 = s1[16];
  assign a_side_nxt.neg2 = s2[16];
  assign a_side_nxt.mag0 = s0[16] ? MW'(-s0) : MW'(s0);
  assign a_side_nxt.mag1 = s1[16] ? MW'(-s1) : MW'(s1);
  assign a_side_nxt.mag2 = s2[16] ? MW'(-s2) : MW'(s2);

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= a_side_nxt;
      a_big_r  <= a_big_nxt;
    end
  end

  // ---- square root, side data delayed alongside ----
  logic [rmq_pkg::ROOT_W-1:0] root;
  side_t                      side_r [SQ];

  rmq_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .big_i  (a_big_r),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= a_side_r;
      for (int i = 1; i < SQ; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---- clamp v, form the three divisions ----
  logic [rmq_pkg::ROOT_W-1:0] vclamp;
  logic [FW-1:0]              vsat;
  logic [rmq_pkg::DEN_W-1:0]  den;
  logic [rmq_pkg::NUM_W-1:0]  num0, num1, num2;
  logic signed [FW-1:0]       d0, d1, d2;
  side_t                      sd;

  assign sd     = side_r[SQ-1];
  assign vclamp = (root < rmq_pkg::V_MIN_Q14) ? rmq_pkg::V_MIN_Q14 : root;
  assign vsat   = ({1'b0, vclamp} > rmq_pkg::ONE_Q14) ? rmq_pkg::ONE_Q14 : {1'b0, vclamp};
  assign den    = {vclamp, 1'b0};
  assign num0   = {sd.mag0, {rmq_pkg::DIV_SHIFT{1'b0}}} + rmq_pkg::NUM_W'(vclamp);
  assign num1   = {sd.mag1, {rmq_pkg::DIV_SHIFT{1'b0}}} + rmq_pkg::NUM_W'(vclamp);
  assign num2   = {sd.mag2, {rmq_pkg::DIV_SHIFT{1'b0}}} + rmq_pkg::NUM_W'(vclamp);

  rmq_div u_div0 (.clk(clk), .en(en), .num_i(num0), .den_i(den), .neg_i(sd.neg0), .q_o(d0));
  rmq_div u_div1 (.clk(clk), .en(en), .num_i(num1), .den_i(den), .neg_i(sd.neg1), .q_o(d1));
  rmq_div u_div2 (.clk(clk), .en(en), .num_i(num2), .den_i(den), .neg_i(sd.neg2), .q_o(d2));

  tail_t tail_r [DV];

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r[0] <= '{best: sd.best, vsat: vsat};
      for (int i = 1; i < DV; i++) begin
        tail_r[i] <= tail_r[i-1];
      end
    end
  end

  // ---- output register: winning component goes to its own slot ----
  rmq_pkg::rmq_out_t out_nxt, out_r;
  tail_t             tl;

  assign tl = tail_r[DV-1];

  always_comb begin
    case (tl.best)
      2'd0: out_nxt = '{quat_x: signed'(tl.vsat), quat_y: d0, quat_z: d1, quat_w: d2};
      2'd1: out_nxt = '{quat_x: d0, quat_y: signed'(tl.vsat), quat_z: d1, quat_w: d2};
      2'd2: out_nxt = '{quat_x: d0, quat_y: d1, quat_z: signed'(tl.vsat), quat_w: d2};
      default: out_nxt = '{quat_x: d0, quat_y: d1, quat_z: d2, quat_w: signed'(tl.vsat)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  // ---- valid chain and global stall ----
  assign en = !vld_r[VLAT-1] || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLAT-2:0], in_valid};
    end
  end

  assign in_stall  = !en;
  assign out_valid = vld_r[VLAT-1];
  assign out_data  = out_r;

  `ASSERT_NORST(a_rst_idle, clk, !rst_n |=> !out_valid, "output valid right after reset")
  `ASSERT_CLK(a_stall_src, clk, rst_n, in_stall |-> (out_valid && out_stall), "input stalled without output stall")
  `ASSERT_CLK(a_v_range, clk, rst_n, vld_r[SQ] |-> (vclamp >= rmq_pkg::V_MIN_Q14 && vsat <= rmq_pkg::ONE_Q14), "v out of range")
  `ASSERT_CLK(a_out_range, clk, rst_n, out_valid |-> (out_data.quat_x >= -16'sd16384 && out_data.quat_x <= 16'sd16384 && out_data.quat_y >= -16'sd16384 && out_data.quat_y <= 16'sd16384 && out_data.quat_z >= -16'sd16384 && out_data.quat_z <= 16'sd16384 && out_data.quat_w >= -16'sd16384 && out_data.quat_w <= 16'sd16384), "output not saturated")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for rotation_matrix_to_quaternion: random and directed matrices.
// Depends on rmq_pkg and the block; predicts each quaternion and compares in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 36;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1625;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rmq_pkg::rmq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rmq_pkg::rmq_out_t out_data;

  rotation_matrix_to_quaternion u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  rmq_pkg::rmq_in_t  matrix_q[$];
  rmq_pkg::rmq_out_t quat_q[$];
  int       err_cnt = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       hold_recv = 1'b0;
  bit       drain_pause = 1'b0;
  bit       stim_done = 1'b0;
  int       wdog = 0;

  // floor(sqrt(n)), bitwise
  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clip_q14(longint v);
    if (v > 16384) return 16'sd16384;
    if (v < -16384) return -16'sd16384;
    return v[15:0];
  endfunction

  // s * 4096 / v, nearest with ties away from zero
  function automatic logic signed [15:0] scale_pair(longint s, longint v);
    longint mag, quo;
    mag = (s < 0) ? -s : s;
    quo = (mag * 8192 + v) / (2 * v);
    return clip_q14((s < 0) ? -quo : quo);
  endfunction

  function automatic rmq_pkg::rmq_out_t predict_quat(rmq_pkg::rmq_in_t m);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
    longint t[4];
    longint sxy, sxz, syz, dx, dy, dz, big, v;
    int best;
    rmq_pkg::rmq_out_t q;
    a11 = m.m_r1c1; a12 = m.m_r1c2; a13 = m.m_r1c3;
    a21 = m.m_r2c1; a22 = m.m_r2c2; a23 = m.m_r2c3;
    a31 = m.m_r3c1; a32 = m.m_r3c2; a33 = m.m_r3c3;
    sxy = a12 + a21; sxz = a31 + a13; syz = a23 + a32;
    dx = a23 - a32; dy = a31 - a13; dz = a12 - a21;
    t[0] = 16384 + a11 - a22 - a33;
    t[1] = 16384 - a11 + a22 - a33;
    t[2] = 16384 - a11 - a22 + a33;
    t[3] = 16384 + a11 + a22 + a33;
    best = 0;
    for (int i = 1; i < 4; i++) if (t[i] > t[best]) best = i;
    big = (t[best] < 0) ? 0 : t[best];
    v = int_root(big << 12);
    if (v < 2048) v = 2048;
    case (best)
      0: begin
        q.quat_x = clip_q14(v); q.quat_y = scale_pair(sxy, v);
        q.quat_z = scale_pair(sxz, v); q.quat_w = scale_pair(dx, v);
      end
      1: begin
        q.quat_x = scale_pair(sxy, v); q.quat_y = clip_q14(v);
        q.quat_z = scale_pair(syz, v); q.quat_w = scale_pair(dy, v);
      end
      2: begin
        q.quat_x = scale_pair(sxz, v); q.quat_y = scale_pair(syz, v);
        q.quat_z = clip_q14(v); q.quat_w = scale_pair(dz, v);
      end
      default: begin
        q.quat_x = scale_pair(dx, v); q.quat_y = scale_pair(dy, v);
        q.quat_z = scale_pair(dz, v); q.quat_w = clip_q14(v);
      end
    endcase
    return q;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  function automatic logic signed [15:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic rmq_pkg::rmq_in_t mat(int a, int b, int c, int d, int e, int f,
                                           int g, int h, int k);
    rmq_pkg::rmq_in_t m;
    m.m_r1c1 = 16'(a); m.m_r1c2 = 16'(b); m.m_r1c3 = 16'(c);
    m.m_r2c1 = 16'(d); m.m_r2c2 = 16'(e); m.m_r2c3 = 16'(f);
    m.m_r3c1 = 16'(g); m.m_r3c2 = 16'(h); m.m_r3c3 = 16'(k);
    return m;
  endfunction

  // random signed diagonal with off-diagonal noise
  function automatic rmq_pkg::rmq_in_t rand_rotation();
    rmq_pkg::rmq_in_t m;
    int dg[3];
    int sgn;
    for (int i = 0; i < 3; i++) begin
      sgn = $urandom_range(0, 1) ? 1 : -1;
      dg[i] = sgn * $urandom_range(0, 16384);
    end
    m = mat(dg[0], $urandom_range(0, 16384) - 8192, $urandom_range(0, 16384) - 8192,
            $urandom_range(0, 16384) - 8192, dg[1], $urandom_range(0, 16384) - 8192,
            $urandom_range(0, 16384) - 8192, $urandom_range(0, 16384) - 8192, dg[2]);
    return m;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (matrix_q.size() != 0 && !drain_pause &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= matrix_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) quat_q.push_back(predict_quat(in_data));
  end

  // receiver and checker
  always @(posedge clk) begin
    rmq_pkg::rmq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_q.size() == 0) begin
        $display("unexpected transaction at %0t", $time);
        err_cnt++;
      end else begin
        want = quat_q.pop_front();
        if (out_data.quat_x !== want.quat_x) report_mismatch("quat_x", out_data.quat_x, want.quat_x);
        if (out_data.quat_y !== want.quat_y) report_mismatch("quat_y", out_data.quat_y, want.quat_y);
        if (out_data.quat_z !== want.quat_z) report_mismatch("quat_z", out_data.quat_z, want.quat_z);
        if (out_data.quat_w !== want.quat_w) report_mismatch("quat_w", out_data.quat_w, want.quat_w);
      end
    end
    out_stall <= hold_recv || ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  initial begin
    wait (stim_done == 0 && rst_n);
    repeat (300) @(posedge clk);
    hold_recv = 1'b1;
    repeat (200) @(posedge clk);
    hold_recv = 1'b0;
  end

  task automatic run_phase(int n, int sidle, int rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    for (int i = 0; i < n; i++)
      matrix_q.push_back(($urandom_range(0, 9) < 7) ? rand_rotation()
        : mat(rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
              rand_entry(), rand_entry(), rand_entry(), rand_entry()));
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int cnt;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: identity, each winning term, ties, extremes, zero, saturation
    matrix_q.push_back(mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    matrix_q.push_back(mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    matrix_q.push_back(mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    matrix_q.push_back(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    matrix_q.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
    matrix_q.push_back(mat(-16384, 100, -200, 300, -16384, 400, -500, 600, -16384));
    matrix_q.push_back(mat(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
    matrix_q.push_back(mat(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
    matrix_q.push_back(mat(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
    matrix_q.push_back(mat(0, 16384, 16384, 16384, 0, 16384, 16384, 16384, 0));
    matrix_q.push_back(mat(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768));
    matrix_q.push_back(mat(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
    matrix_q.push_back(mat(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    matrix_q.push_back(mat(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
    matrix_q.push_back(mat(5000, 5000, -5000, -5000, 5000, 5000, 5000, -5000, 5000));
    matrix_q.push_back(mat(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384,
                           -16384));
    while (matrix_q.size() != 0) @(posedge clk);
    run_phase(N_RANDOM / 5, 0, 0);
    run_phase(N_RANDOM / 5, 62, 0);
    run_phase(N_RANDOM / 5, 0, 62);
    // sender waits for the pipeline to drain completely
    drain_pause = 1'b1;
    cnt = 0;
    while ((quat_q.size() != 0 || in_valid) && cnt < 100000) begin
      @(posedge clk);
      cnt++;
    end
    drain_pause = 1'b0;
    run_phase(N_RANDOM / 5, 33, 33);
    run_phase(N_RANDOM / 5, 0, 0);
    while (in_valid) @(posedge clk);
    stim_done = 1'b1;
    recv_stall_pct = 0;
    cnt = 0;
    while (quat_q.size() != 0 && cnt < 100000) begin
      @(posedge clk);
      cnt++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (err_cnt == 0 && quat_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
